[hdl/tww_pkg.sv]
// shared constants for the tilt window ventilation flow pipeline
`timescale 1ns / 1ps
`default_nettype none
package tww_pkg;

	localparam logic [16:0] KELVIN_Q8 = 17'd69926;
	localparam logic [26:0] CK_C1_Q32 = 27'd79886392;
	localparam logic [18:0] CK_C2_Q32 = 19'd511101;
	localparam logic [18:0] CK_C3_Q40 = 19'd285873;
	localparam logic [18:0] CD_K1_Q24 = 19'd291924;
	localparam logic [24:0] CD_K2_Q28 = 25'd24910810;
	localparam logic [26:0] CD_K3_Q28 = 27'd110488034;
	localparam logic [16:0] GM_Q16    = 17'd71434;

	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 23;

	typedef enum logic [1:0] {
		REG_MAX_TILT_ANGLE = 2'd0,
		REG_WINDOW_HEIGHT  = 2'd1,
		REG_WINDOW_WIDTH   = 2'd2
	} cfg_reg_t;

endpackage
`default_nettype wire

[hdl/tww_div.sv]
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tww_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] dmag,
	input  wire logic [17:0] divisor,
	output logic [30:0]      quot
);

	localparam int N = tww_pkg::DIV_STEPS;

	logic [17:0] rem_s [0:N-1];
	logic [17:0] dvs_s [0:N-1];
	logic [30:0] quo_s [0:N-1];

	for (genvar gi = 0; gi < N; gi++) begin : g_stage
		logic [17:0] rin;
		logic [17:0] din;
		logic [30:0] qin;
		logic [18:0] tr;
		logic        ge;

		if (gi == 0) begin : g_first
			assign rin = {2'b00, dmag};
			assign din = divisor;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[gi-1];
			assign din = dvs_s[gi-1];
			assign qin = quo_s[gi-1];
		end

		assign tr = {rin, 1'b0};
		assign ge = tr >= {1'b0, din};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[gi] <= ge ? 18'(tr - {1'b0, din}) : tr[17:0];
				dvs_s[gi] <= din;
				quo_s[gi] <= {qin[29:0], ge};
			end
		end
	end

	assign quot = quo_s[N-1];

endmodule
`default_nettype wire

[hdl/tww_sqrt.sv]
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tww_sqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [44:0] rad,
	output logic [22:0]      root
);

	localparam int N = tww_pkg::SQRT_STEPS;

	logic [45:0] x_s    [0:N-1];
	logic [24:0] rem_s  [0:N-1];
	logic [22:0] root_s [0:N-1];

	for (genvar gi = 0; gi < N; gi++) begin : g_stage
		logic [45:0] xin;
		logic [24:0] rin;
		logic [22:0] qin;
		logic [26:0] remsh;
		logic [26:0] trial;
		logic        ge;

		if (gi == 0) begin : g_first
			assign xin = {1'b0, rad};
			assign rin = '0;
			assign qin = '0;
		end else begin : g_next
			assign xin = x_s[gi-1];
			assign rin = rem_s[gi-1];
			assign qin = root_s[gi-1];
		end

		assign remsh = {rin, xin[45:44]};
		assign trial = {2'b00, qin, 2'b01};
		assign ge    = remsh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[gi]    <= {xin[43:0], 2'b00};
				rem_s[gi]  <= ge ? 25'(remsh - trial) : remsh[24:0];
				root_s[gi] <= {qin[21:0], ge};
			end
		end
	end

	assign root = root_s[N-1];

endmodule
`default_nettype wire

[hdl/tilt_window_ventilation_flow.sv]
// top level of the tilt window ventilation flow pipeline
//
// channel  dir  handshake               payload
// s_*      in   s_tvalid / s_tready     tdata: ambient_temp, inside_temp, opening
// m_*      out  m_tvalid / m_tready     tdata: flow_rate
// cfg_*    in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one transaction per cycle in; the path runs through the 31 stage divider and
// the 23 stage square root in series
// the whole pipeline advances together; it halts only while the output holds a
// result that is not taken
// reset clears the valid bits and the three registers; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none
module tilt_window_ventilation_flow (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // ambient_temp, inside_temp, opening
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // flow_rate
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int DIV_OUT   = 1 + tww_pkg::DIV_STEPS;
	localparam int ROOT_OUT  = DIV_OUT + 3 + tww_pkg::SQRT_STEPS;
	localparam int LAT       = ROOT_OUT + 1;
	localparam int SIDE_DLY  = ROOT_OUT - 7;

	logic [15:0] max_tilt_angle_q;
	logic [14:0] window_height_q;
	logic [14:0] window_width_q;

	logic           adv;
	logic [LAT:1]   vld_s;

	assign cfg_ready = 1'b1;
	assign adv       = !vld_s[LAT] || m_tready;
	assign s_tready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tilt_angle_q <= '0;
			window_height_q  <= '0;
			window_width_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tww_pkg::REG_MAX_TILT_ANGLE: max_tilt_angle_q <= cfg_data;
				tww_pkg::REG_WINDOW_HEIGHT:  window_height_q  <= cfg_data[14:0];
				tww_pkg::REG_WINDOW_WIDTH:   window_width_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	// stage 1: kelvin, difference, sum, raw angle
	logic signed [17:0] t1_k, t2_k, t_diff;
	logic [15:0] dmag_s1;
	logic [17:0] sum_s1;
	logic [31:0] afull_s1;

	always_comb begin
		t1_k   = 18'(signed'(s_tdata[15:0])) + signed'({1'b0, tww_pkg::KELVIN_Q8});
		t2_k   = 18'(signed'(s_tdata[31:16])) + signed'({1'b0, tww_pkg::KELVIN_Q8});
		t_diff = t1_k - t2_k;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dmag_s1  <= t_diff[17] ? 16'(-t_diff) : t_diff[15:0];
			sum_s1   <= 18'(t1_k[16:0]) + 18'(t2_k[16:0]);
			afull_s1 <= 32'(s_tdata[47:32]) * 32'(max_tilt_angle_q);
		end
	end

	// stages 2 to 7: angle cubic and discharge coefficient
	logic [24:0] a_s2;
	logic [33:0] a2_s2;
	logic [35:0] ck1_s2, ck1_s3, ck1_s4;
	logic [27:0] aw_s2;
	logic [42:0] a3_s3;
	logic [36:0] ck2_s3, ck2_s4;
	logic [46:0] cdk1_s3;
	logic [41:0] cdk3_s3;
	logic [39:0] cdk2_s3;
	logic [37:0] ck3_s4;
	logic        neg_s4, neg_s5, neg_s6, neg_s7;
	logic [31:0] cd24_s4, cd24_s5;
	logic [22:0] ck16_s5;
	logic [34:0] pp_s6;
	logic [37:0] pp2_s7;

	logic [24:0] a_w;
	logic [49:0] a2_p;
	logic [51:0] ck1_p;
	logic [39:0] aw_p;
	logic [58:0] a3_p;
	logic [52:0] ck2_p;
	logic [61:0] ck3_p;
	logic signed [48:0] cd_w;
	logic [48:0] cd_mag;
	logic signed [39:0] ck_w;
	logic [54:0] pp_p;
	logic [49:0] pp2_p;

	always_comb begin
		a_w    = afull_s1[31:7];
		a2_p   = 50'(a_w) * 50'(a_w);
		ck1_p  = 52'(a_w) * 52'(tww_pkg::CK_C1_Q32);
		aw_p   = 40'(a_w) * 40'(window_width_q);
		a3_p   = 59'(a2_s2) * 59'(a_s2);
		ck2_p  = 53'(a2_s2) * 53'(tww_pkg::CK_C2_Q32);
		ck3_p  = 62'(a3_s3) * 62'(tww_pkg::CK_C3_Q40);
		cd_w   = signed'({2'b00, cdk1_s3}) + signed'({7'd0, cdk3_s3})
		       - signed'({9'd0, cdk2_s3});
		cd_mag = cd_w[48] ? 49'(-cd_w) : cd_w;
		ck_w   = signed'({4'd0, ck1_s4}) - signed'({3'd0, ck2_s4})
		       + signed'({2'd0, ck3_s4});
		pp_p   = 55'(cd24_s5) * 55'(ck16_s5);
		pp2_p  = 50'(pp_s6) * 50'(window_height_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2    <= a_w;
			a2_s2   <= a2_p[49:16];
			ck1_s2  <= ck1_p[51:16];
			aw_s2   <= aw_p[39:12];

			a3_s3   <= a3_p[58:16];
			ck1_s3  <= ck1_s2;
			ck2_s3  <= ck2_p[52:16];
			cdk1_s3 <= 47'(aw_s2) * 47'(tww_pkg::CD_K1_Q24);
			cdk3_s3 <= 42'(window_width_q) * 42'(tww_pkg::CD_K3_Q28);
			cdk2_s3 <= 40'(window_height_q) * 40'(tww_pkg::CD_K2_Q28);

			ck1_s4  <= ck1_s3;
			ck2_s4  <= ck2_s3;
			ck3_s4  <= ck3_p[61:24];
			neg_s4  <= cd_w[48];
			cd24_s4 <= cd_mag[47:16];

			neg_s5  <= neg_s4;
			cd24_s5 <= cd24_s4;
			ck16_s5 <= ck_w[39] ? '0 : ck_w[38:16];

			neg_s6  <= neg_s5;
			pp_s6   <= pp_p[54:20];

			neg_s7  <= neg_s6;
			pp2_s7  <= pp2_p[49:12];
		end
	end

	// side values wait for the root
	logic [37:0] pp2_dly_s [0:SIDE_DLY-1];
	logic        neg_dly_s [0:SIDE_DLY-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			pp2_dly_s[0] <= pp2_s7;
			neg_dly_s[0] <= neg_s7;
			for (int i = 1; i < SIDE_DLY; i++) begin
				pp2_dly_s[i] <= pp2_dly_s[i-1];
				neg_dly_s[i] <= neg_dly_s[i-1];
			end
		end
	end

	// relative temperature difference
	logic [30:0] dt_w;

	tww_div u_div (
		.clk     (clk),
		.en      (adv),
		.dmag    (dmag_s1),
		.divisor (sum_s1),
		.quot    (dt_w)
	);

	// root operand
	logic [45:0] mh_s33;
	logic [39:0] lo_s34, hi_s34;
	logic [44:0] rad_s35;
	logic [62:0] rad_p;

	assign rad_p = (63'(hi_s34) << 23) + 63'(lo_s34);

	always_ff @(posedge clk) begin
		if (adv) begin
			mh_s33  <= 46'(dt_w) * 46'(window_height_q);
			lo_s34  <= 40'(mh_s33[22:0]) * 40'(tww_pkg::GM_Q16);
			hi_s34  <= 40'(mh_s33[45:23]) * 40'(tww_pkg::GM_Q16);
			rad_s35 <= rad_p[62:18];
		end
	end

	logic [22:0] root_w;

	tww_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s35),
		.root (root_w)
	);

	// final product and sign
	logic [60:0] fin_p;
	logic [31:0] mag_w;
	logic [31:0] flow_w;
	logic [31:0] flow_s59;
	logic        neg_s59;

	always_comb begin
		fin_p = 61'(pp2_dly_s[SIDE_DLY-1]) * 61'(root_w);
		mag_w = {1'b0, fin_p[60:30]};
		if (neg_dly_s[SIDE_DLY-1]) begin
			flow_w = 32'(-mag_w);
		end else begin
			flow_w = mag_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flow_s59 <= flow_w;
			neg_s59  <= neg_dly_s[SIDE_DLY-1];
		end
	end

	assign m_tvalid = vld_s[LAT];
	assign m_tdata  = flow_s59;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output stalled");

	a_valid_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s[LAT-1]) |=> m_tvalid)
		else $error("result lost at output stage");

	a_sign_follows_cd: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !neg_s59) |-> !m_tdata[31])
		else $error("positive coefficient gave negative flow");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(flow_s59))
		else $error("stalled result changed");

endmodule
`default_nettype wire

[verif/tb_tilt_window_ventilation_flow.sv]
// self-checking testbench for the tilt window ventilation flow pipeline
`timescale 1ns / 1ps
`default_nettype none
module tb_tilt_window_ventilation_flow;

	typedef struct {
		logic [15:0] ambient;
		logic [15:0] indoor;
		logic [15:0] opening;
		logic        known;
		logic [31:0] flow;
	} vent_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // ambient_temp, inside_temp, opening
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // flow_rate
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	logic [15:0] tilt_max;
	logic [14:0] win_h;
	logic [14:0] win_w;
	logic [31:0] flow_queue[$];
	int          errors;
	int          idle_cycles;
	int          flows_seen;
	int          neg_seen;
	int          stall_mode;
	vent_row_t   rows[$];

	tilt_window_ventilation_flow uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bit_val;
		res = 0;
		bit_val = 64'd1 << 62;
		while (bit_val > x) bit_val = bit_val >> 2;
		while (bit_val != 0) begin
			if (x >= res + bit_val) begin
				x = x - (res + bit_val);
				res = (res >> 1) + bit_val;
			end else begin
				res = res >> 1;
			end
			bit_val = bit_val >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] vent_flow(input logic [15:0] amb, input logic [15:0] ins,
			input logic [15:0] opn);
		longint      t1, t2, d, ck, cd;
		logic [63:0] dmag, dt, a, a2, a3, ck16, aw, cd24, rad, root, p, h, w;
		logic        neg;
		t1 = longint'($signed(amb)) + 69926;
		t2 = longint'($signed(ins)) + 69926;
		h = 64'(win_h);
		w = 64'(win_w);
		d = t1 - t2;
		dmag = d < 0 ? -d : d;
		dt = ((2 * dmag) << 30) / (t1 + t2);
		a = (64'(opn) * 64'(tilt_max)) >> 7;
		a2 = (a * a) >> 16;
		a3 = (a2 * a) >> 16;
		ck = longint'((64'd79886392 * a) >> 16) - longint'((64'd511101 * a2) >> 16)
			+ longint'((64'd285873 * a3) >> 24);
		if (ck < 0) ck = 0;
		ck16 = ck >> 16;
		aw = (a * w) >> 12;
		cd = longint'(64'd291924 * aw) + longint'(64'd110488034 * w)
			- longint'(64'd24910810 * h);
		neg = cd < 0;
		cd24 = (neg ? -cd : cd) >> 16;
		rad = ((dt * h) * 64'd71434) >> 18;
		root = floor_sqrt(rad);
		p = (cd24 * ck16) >> 20;
		p = (p * h) >> 12;
		p = (p * root) >> 30;
		if (neg) begin
			if (p > 64'h80000000) p = 64'h80000000;
			return 32'(64'd0 - p);
		end
		if (p > 64'h7FFFFFFF) p = 64'h7FFFFFFF;
		return p[31:0];
	endfunction

	task automatic write_reg(input tww_pkg::cfg_reg_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tww_pkg::REG_MAX_TILT_ANGLE: tilt_max = val;
			tww_pkg::REG_WINDOW_HEIGHT: win_h = val[14:0];
			tww_pkg::REG_WINDOW_WIDTH: win_w = val[14:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_window(input logic [15:0] ang, input logic [15:0] hh, input logic [15:0] ww);
		write_reg(tww_pkg::REG_MAX_TILT_ANGLE, ang);
		write_reg(tww_pkg::REG_WINDOW_HEIGHT, hh);
		write_reg(tww_pkg::REG_WINDOW_WIDTH, ww);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_flows();
		while (flow_queue.size() != 0) @(negedge clk);
		repeat (70) @(negedge clk);
	endtask

	// sends one item; holds tvalid if another item follows straight after it
	task automatic send_item(input logic [15:0] amb, input logic [15:0] ins,
			input logic [15:0] opn, input logic known, input logic [31:0] flow, input bit more);
		s_tvalid <= 1'b1;
		s_tdata <= {opn, ins, amb};
		do @(posedge clk); while (!s_tready);
		flow_queue.push_back(known ? flow : vent_flow(amb, ins, opn));
		@(negedge clk);
		if (!more) s_tvalid <= 1'b0;
	endtask

	task automatic random_items(input int count);
		int          left;
		int          burst;
		int          gap;
		logic [15:0] amb, ins, opn;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > left) burst = left;
			gap = ($urandom_range(0, 2) != 0) ? int'($urandom_range(1, 6)) : 0;
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					amb = 16'($urandom);
					ins = 16'($urandom);
					opn = 16'($urandom);
				end else begin
					amb = 16'($urandom_range(0, 38400) - 12800);
					ins = 16'($urandom_range(0, 38400) - 12800);
					opn = 16'($urandom_range(0, 32768));
				end
				send_item(amb, ins, opn, 1'b0, 32'd0,
					(i != burst - 1) || (gap == 0 && left > burst));
			end
			left -= burst;
			if (gap != 0) repeat (gap) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			flows_seen++;
			if ($signed(m_tdata) < 0) neg_seen++;
			if (flow_queue.size() == 0) begin
				$error("flow_rate with no transaction expected: %h", m_tdata);
				errors++;
			end else begin
				if (m_tdata !== flow_queue[0]) begin
					$error("flow_rate expected %h actual %h", flow_queue[0], m_tdata);
					errors++;
				end
				void'(flow_queue.pop_front());
			end
		end
	end

	// receiver stall pattern changes phase over time
	always @(negedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 1) != 0);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		errors = 0;
		flows_seen = 0;
		neg_seen = 0;
		stall_mode = 0;
		idle_cycles = 0;
		tilt_max = 0;
		win_h = 0;
		win_w = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = tww_pkg::REG_MAX_TILT_ANGLE;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers at reset give zero flow
		rows.push_back('{16'h6400, 16'hCE00, 16'h8000, 1'b1, 32'd0});
		rows.push_back('{16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 32'd0});
		foreach (rows[i]) send_item(rows[i].ambient, rows[i].indoor, rows[i].opening,
			rows[i].known, rows[i].flow, i != rows.size() - 1);
		drain_flows();

		set_window(16'd46080, 16'd8192, 16'd4096);
		rows.delete();
		rows.push_back('{16'h0000, 16'h0000, 16'h8000, 1'b1, 32'd0});   // no temperature difference
		rows.push_back('{16'h1400, 16'h1400, 16'h4000, 1'b1, 32'd0});
		rows.push_back('{16'h6400, 16'hCE00, 16'h8000, 1'b0, 32'd0});   // extremes
		rows.push_back('{16'hCE00, 16'h6400, 16'h8000, 1'b0, 32'd0});
		rows.push_back('{16'h0000, 16'h1400, 16'h0000, 1'b1, 32'd0});   // closed window
		rows.push_back('{16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 32'd0});   // out of range
		rows.push_back('{16'h8000, 16'h7FFF, 16'h0001, 1'b0, 32'd0});
		rows.push_back('{16'h0A00, 16'h1400, 16'h2000, 1'b0, 32'd0});
		foreach (rows[i]) send_item(rows[i].ambient, rows[i].indoor, rows[i].opening,
			rows[i].known, rows[i].flow, i != rows.size() - 1);
		drain_flows();

		// tall narrow window drives the discharge coefficient negative
		set_window(16'd2560, 16'hFFFF, 16'd1);
		send_item(16'h6400, 16'hCE00, 16'h8000, 1'b0, 32'd0, 1'b1);
		send_item(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 32'd0, 1'b0);
		// largest settings push toward saturation
		drain_flows();
		set_window(16'hFFFF, 16'h7FFF, 16'h7FFF);
		send_item(16'h6400, 16'hCE00, 16'h8000, 1'b0, 32'd0, 1'b1);
		send_item(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 32'd0, 1'b0);
		drain_flows();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_window(16'd46080, 16'd6000, 16'd3500);
				1: set_window(16'd0, 16'd4096, 16'd4096);
				2: set_window(16'hFFFF, 16'd32767, 16'd0);
				default: set_window(16'($urandom_range(0, 46080)), 16'($urandom_range(0, 32767)),
					16'($urandom_range(0, 32767)));
			endcase
			stall_mode = ph % 3;
			random_items(90);
			drain_flows();
		end

		$display("covered %0d flow results (%0d negative) over several window settings",
			flows_seen, neg_seen);
		$display("random bursts with sender gaps and receiver stalls, incl. full drain pauses");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
hdl/tww_pkg.sv
hdl/tww_div.sv
hdl/tww_sqrt.sv
hdl/tilt_window_ventilation_flow.sv
verif/tb_tilt_window_ventilation_flow.sv
